// ===== hw/rtl/rnfc_pkg.sv =====
package rnfc_pkg;

	localparam int RING_DEPTH = 6;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int RANK_W     = $clog2(RING_DEPTH);
	localparam int MED_RANK   = RING_DEPTH / 2 - 1;

	localparam int FLOOR_W = 10;
	localparam int RUN_W   = 3;

	// (8*floor + median) / 9 by reciprocal: exact for sums below 2**17 / 4
	localparam int SUM_W     = FLOOR_W + 4;
	localparam int RECIP_W   = 15;
	localparam int DIV_SHIFT = 17;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << DIV_SHIFT) + 8) / 9);

	localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(250);
	localparam logic [RUN_W-1:0]   NEED_RESET  = RUN_W'(6);

	localparam logic CMD_NOISE = 1'b0;
	localparam logic CMD_CCA   = 1'b1;

	typedef enum logic [1:0] {
		V_PENDING = 2'd0,
		V_CLEAR   = 2'd1,
		V_BUSY    = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MEDIAN,
		ST_MUL,
		ST_FLOOR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic cca_step;
		logic ring_write;
		logic med_step;
		logic mul_step;
		logic floor_load;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_cca;
		logic idle;
		logic med_last;
	} dp_status_t;

endpackage

// ===== hw/rtl/rssi_noise_floor_cca.sv =====
// channel   direction  signals
// request   in         in_valid, in_ready, cmd, rssi, radio_idle
// result    out        out_valid, out_ready, noise_floor, verdict
// config    in         cfg_wen, cfg_wdata (clear_samples_needed)
//
// A CCA request or a noise request with the radio busy goes from decode to emit.
// An idle noise request writes the ring in decode; then the median search
// ranks one ring entry a cycle, then one multiply and one floor update.
// Reset: floor 250, run 0, ring unprimed, clear_samples_needed 6.
// A result waits in the output register; the next request is taken meanwhile.
module rssi_noise_floor_cca (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [rnfc_pkg::FLOOR_W-1:0] rssi,
	input  logic                         radio_idle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rnfc_pkg::FLOOR_W-1:0] noise_floor,
	output logic [1:0]                   verdict,
	input  logic                         cfg_wen,
	input  logic [rnfc_pkg::RUN_W-1:0]   cfg_wdata
);
	import rnfc_pkg::*;

	ctl_cmd_t   ctl;
	dp_status_t sts;
	verdict_t   verdict_w;

	rnfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (ctl)
	);

	rnfc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl),
		.sts         (sts),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_cmd      (cmd),
		.in_rssi     (rssi),
		.in_idle     (radio_idle),
		.out_floor   (noise_floor),
		.out_verdict (verdict_w)
	);

	assign verdict = verdict_w;

endmodule

// ===== hw/rtl/rnfc_ctrl.sv =====
module rnfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rnfc_pkg::dp_status_t sts,
	output rnfc_pkg::ctl_cmd_t  cmd
);
	import rnfc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (!sts.is_cca && sts.idle) state_d = ST_MEDIAN;
				else                         state_d = ST_EMIT;
			end
			ST_MEDIAN: begin
				if (sts.med_last) state_d = ST_MUL;
			end
			ST_MUL:   state_d = ST_FLOOR;
			ST_FLOOR: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load_in = in_valid;
			ST_DECODE: begin
				cmd.cca_step   = sts.is_cca;
				cmd.ring_write = !sts.is_cca && sts.idle;
			end
			ST_MEDIAN: cmd.med_step   = 1'b1;
			ST_MUL:    cmd.mul_step   = 1'b1;
			ST_FLOOR:  cmd.floor_load = 1'b1;
			ST_EMIT:   cmd.out_load   = !out_valid_q || out_ready;
			default:   cmd = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result load did not raise out_valid");
`endif

endmodule

// ===== hw/rtl/rnfc_dp.sv =====
module rnfc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rnfc_pkg::ctl_cmd_t                cmd,
	output rnfc_pkg::dp_status_t              sts,
	input  logic                              cfg_wen,
	input  logic [rnfc_pkg::RUN_W-1:0]        cfg_wdata,
	input  logic                              in_cmd,
	input  logic [rnfc_pkg::FLOOR_W-1:0]      in_rssi,
	input  logic                              in_idle,
	output logic [rnfc_pkg::FLOOR_W-1:0]      out_floor,
	output rnfc_pkg::verdict_t                out_verdict
);
	import rnfc_pkg::*;

	logic                 cmd_q;
	logic [FLOOR_W-1:0]   rssi_q;
	logic                 idle_q;
	logic [RUN_W-1:0]     need_q;
	logic [RUN_W-1:0]     run_q;
	logic                 primed_q;
	logic [IDX_W-1:0]     widx_q;
	logic [IDX_W-1:0]     midx_q;
	logic [FLOOR_W-1:0]   ring_q [RING_DEPTH];
	logic [FLOOR_W-1:0]   median_q;
	logic [PROD_W-1:0]    prod_q;
	logic [FLOOR_W-1:0]   floor_q;
	verdict_t             verdict_q;

	logic [RUN_W-1:0]     need_eff;
	logic [RUN_W-1:0]     run_inc;
	logic                 pass;
	logic [IDX_W-1:0]     widx_nxt;
	logic [FLOOR_W-1:0]   cand;
	logic [RANK_W-1:0]    rank;
	logic [SUM_W-1:0]     blend;

	assign need_eff = (need_q == '0) ? RUN_W'(1) : need_q;
	assign run_inc  = run_q + RUN_W'(1);
	assign pass     = idle_q && (rssi_q >= floor_q);
	assign widx_nxt = (widx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : widx_q + IDX_W'(1);
	assign cand     = ring_q[midx_q];
	assign blend    = {1'b0, floor_q, 3'b000} + SUM_W'(median_q);

	// rank with ties broken by position, so every entry has a distinct rank
	always_comb begin
		rank = '0;
		for (int k = 0; k < RING_DEPTH; k++) begin
			if (ring_q[k] < cand || (ring_q[k] == cand && IDX_W'(k) < midx_q))
				rank = rank + RANK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q    <= NEED_RESET;
			run_q     <= '0;
			primed_q  <= 1'b0;
			widx_q    <= '0;
			floor_q   <= FLOOR_RESET;
			midx_q    <= '0;
			verdict_q <= V_PENDING;
		end else begin
			if (cfg_wen) need_q <= cfg_wdata;
			if (cmd.load_in) verdict_q <= V_PENDING;
			if (cmd.cca_step) begin
				if (!pass) begin
					run_q     <= '0;
					verdict_q <= V_BUSY;
				end else if (run_inc >= need_eff) begin
					run_q     <= '0;
					verdict_q <= V_CLEAR;
				end else begin
					run_q <= run_inc;
				end
			end
			if (cmd.ring_write) begin
				primed_q <= 1'b1;
				midx_q   <= '0;
				if (primed_q) widx_q <= widx_nxt;
			end
			if (cmd.med_step) midx_q <= midx_q + IDX_W'(1);
			if (cmd.floor_load) floor_q <= prod_q[DIV_SHIFT +: FLOOR_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= in_cmd;
			rssi_q <= in_rssi;
			idle_q <= in_idle;
		end
		if (cmd.ring_write) begin
			if (!primed_q) begin
				for (int k = 0; k < RING_DEPTH; k++) ring_q[k] <= rssi_q;
			end else begin
				ring_q[widx_nxt] <= rssi_q;
			end
		end
		if (cmd.med_step && rank == RANK_W'(MED_RANK)) median_q <= cand;
		if (cmd.mul_step) prod_q <= PROD_W'(blend) * PROD_W'(RECIP);
		if (cmd.out_load) begin
			out_floor   <= floor_q;
			out_verdict <= verdict_q;
		end
	end

	assign sts.is_cca   = (cmd_q == CMD_CCA);
	assign sts.idle     = idle_q;
	assign sts.med_last = (midx_q == IDX_W'(RING_DEPTH - 1));

`ifndef NO_ASSERTIONS
	a_clear_resets_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cca_step |=> (verdict_q != V_CLEAR || run_q == '0))
		else $error("clear verdict left a run behind");
	a_write_primes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_write |=> primed_q)
		else $error("ring write did not prime the ring");
	a_median_needs_prime: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.med_step |-> primed_q)
		else $error("median search on an unprimed ring");
`endif

endmodule
